// ----- sv/htmg_pkg.sv -----
// Package for the histogram trimmed mean gain block.
// Shared constants, register indexes, the back-end state enum and the front-to-back item struct.
package htmg_pkg;

  localparam int unsigned DefBins       = 256;
  localparam int unsigned DefCountWidth = 20;
  localparam int unsigned CfgWidth      = 20;
  localparam int unsigned RowWidth      = 12;
  localparam int unsigned QDepth        = 4;

  localparam logic [1:0] RegMode      = 2'd0;
  localparam logic [1:0] RegFirstRow  = 2'd1;
  localparam logic [1:0] RegLastRow   = 2'd2;
  localparam logic [1:0] RegRefCount  = 2'd3;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatEmpty    = 2'd1;
  localparam logic [1:0] StatNoThresh = 2'd2;

  typedef enum logic [2:0] {
    BK_CLEAR, BK_RUN, BK_WALK, BK_DIVA, BK_DIVG, BK_DONE
  } back_state_e;

  // one classified pixel passed from front to back
  typedef struct packed {
    logic       count;
    logic [7:0] pixel;
    logic       last;
  } item_t;

endpackage

// ----- sv/htmg_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module htmg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- sv/htmg_front.sv -----
// Front end: band check and bin clamp, pushes classified items into a short queue.
// Depends on htmg_pkg.
module htmg_front #(
  parameter int unsigned Bins = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            take_i,
  input  logic [7:0]                      pixel_i,
  input  logic [htmg_pkg::RowWidth-1:0]   row_i,
  input  logic                            last_i,
  input  logic [htmg_pkg::RowWidth-1:0]   first_row_i,
  input  logic [htmg_pkg::RowWidth-1:0]   last_row_i,
  input  logic                            pop_i,
  output logic                            full_o,
  output logic                            empty_o,
  output htmg_pkg::item_t                 head_o
);
  import htmg_pkg::*;
  localparam int unsigned PtrW = $clog2(QDepth);

  item_t           fifo_q [QDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  item_t           it;

  always_comb begin
    it.count = (row_i >= first_row_i) && (row_i <= last_row_i);
    if (Bins < 256 && {24'd0, pixel_i} >= 32'(Bins)) it.pixel = 8'(Bins - 1);
    else it.pixel = pixel_i;
    it.last = last_i;
  end

  assign full_o  = (cnt_q == (PtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (take_i) fifo_q[wp_q] <= it;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (take_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(take_i) - (PtrW+1)'(pop_i);
    end
  end
endmodule

// ----- sv/htmg_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient saturated to 16 bits.
// No dependencies.
module htmg_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 40
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [15:0]     quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, quo_q;
  logic [DenW:0]   rem_q, trial;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;

  assign trial  = {rem_q[DenW-1:0], num_q[NumW-1]};
  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = (quo_q > NumW'(16'hFFFF)) ? 16'hFFFF : quo_q[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1; cnt_q <= CntW'(NumW);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i; den_q <= den_i; rem_q <= '0; quo_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      num_q <= num_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end
endmodule

// ----- sv/htmg_back.sv -----
// Back end: histogram update with read-modify-write, frame-end walk and divisions.
// Depends on htmg_pkg, htmg_ram and htmg_div.
module htmg_back #(
  parameter int unsigned Bins       = 256,
  parameter int unsigned CountWidth = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  htmg_pkg::item_t               head_i,
  output logic                          pop_o,
  output logic                          idle_o,
  input  logic                          mode_i,
  input  logic [htmg_pkg::CfgWidth-1:0] ref_i,
  output logic                          valid_o,
  output logic [15:0]                   gain_o,
  output logic [15:0]                   avg_o,
  output logic [7:0]                    low_bin_o,
  output logic [7:0]                    high_bin_o,
  output logic [1:0]                    status_o
);
  import htmg_pkg::*;
  localparam int unsigned AW   = $clog2(Bins);
  localparam int unsigned AccW = CountWidth + AW + 1;
  localparam int unsigned LvlW = CountWidth + 2 * AW;
  localparam int unsigned NumW = LvlW + 8;
  localparam int unsigned DenW = LvlW;
  localparam logic [CountWidth-1:0] CntMax = '1;

  back_state_e state_q, state_d;
  logic [AW-1:0]         clr_q, idx_q;
  logic [AW:0]           step_q;   // walk read position, runs ahead of idx_q to cover the registered read
  logic                  mode_q, phase_q, started_q, ended_q, upd_q, fin_q, hit_q;
  logic [AW-1:0]         upd_addr_q, low_q, high_q;
  logic [AccW-1:0]       acc_q, eff_q;
  logic [LvlW-1:0]       lvl_q;
  logic [15:0]           avg_q, gain_q;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [CountWidth-1:0] wdata, rdata;
  logic                  div_start, div_done;
  logic [NumW-1:0]       div_num;
  logic [DenW-1:0]       div_den;
  logic [15:0]           div_quo;
  logic [AccW+3:0]       acc5, ref5, ref4;
  logic [AccW-1:0]       acc_n;
  logic [LvlW-1:0]       prod;
  logic [AW-1:0]         bin_w;
  logic                  lo_hit, top_hit;

  htmg_ram #(.Width(CountWidth), .Depth(Bins)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  htmg_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // bin of the data now on rdata during the walk
  assign bin_w   = mode_q ? AW'(Bins - 1) - idx_q : idx_q;
  assign acc5    = (AccW+4)'(acc_q) * 5;
  assign ref5    = (AccW+4)'(ref_i);
  assign ref4    = (AccW+4)'(ref_i) << 2;
  assign acc_n   = acc_q + AccW'(rdata);
  assign prod    = LvlW'(rdata) * LvlW'(bin_w);
  assign lo_hit  = !started_q && (acc5 >= ref5);
  assign top_hit = ((AccW+4)'(acc_n) * 20) >= ref5;

  // in the run state, pop one item per cycle when no read-modify-write or frame end is pending
  assign pop_o  = (state_q == BK_RUN) && !empty_i && !upd_q && !fin_q;
  assign idle_o = (state_q == BK_RUN) && empty_i && !upd_q;

  always_comb begin
    state_d = state_q; we = 1'b0; waddr = upd_addr_q; wdata = '0;
    raddr = AW'(head_i.pixel); div_start = 1'b0;
    div_num = '0; div_den = '0;
    case (state_q)
      BK_CLEAR: begin
        we = 1'b1; waddr = clr_q;
        if (clr_q == AW'(Bins - 1)) state_d = BK_RUN;
      end
      BK_RUN: begin
        if (upd_q) begin
          we = 1'b1;
          wdata = (rdata == CntMax) ? rdata : rdata + 1'b1;
        end
        // last pixel's write-back lands this cycle, walk reads start next
        if (fin_q) state_d = BK_WALK;
      end
      BK_WALK: begin
        raddr = mode_q ? AW'(Bins - 1) - AW'(step_q) : AW'(step_q);
        if (ended_q) begin
          div_start = 1'b1;
          div_num = NumW'(lvl_q) << 8;
          div_den = DenW'(eff_q);
          state_d = BK_DIVA;
        end
      end
      BK_DIVA: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num = NumW'(eff_q) * NumW'(mode_q ? 100 : 80) << 8;
          div_den = lvl_q;
          state_d = BK_DIVG;
        end
      end
      BK_DIVG: if (div_done) state_d = BK_DONE;
      BK_DONE: state_d = BK_CLEAR;
      default: state_d = BK_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR; clr_q <= '0; upd_q <= 1'b0; fin_q <= 1'b0; valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_o <= (state_q == BK_DONE);
      upd_q   <= pop_o && head_i.count;
      fin_q   <= pop_o && head_i.last;
      if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) upd_addr_q <= AW'(head_i.pixel);
    case (state_q)
      BK_RUN: begin
        if (pop_o && head_i.last) begin
          mode_q <= mode_i; step_q <= '0; phase_q <= 1'b0; idx_q <= '0;
          acc_q <= '0; eff_q <= '0; lvl_q <= '0; started_q <= 1'b0; ended_q <= 1'b0;
          low_q <= '0; high_q <= '0;
        end
      end
      BK_WALK: begin
        if (!ended_q) begin
          step_q <= step_q + 1'b1;
          if (!phase_q) begin
            phase_q <= 1'b1;  // first read still in flight
          end else begin
            idx_q <= idx_q + 1'b1;
            if (!mode_q) begin
              if (lo_hit) begin
                started_q <= 1'b1; low_q <= idx_q;
              end
              if (acc5 >= ref4) begin
                ended_q <= 1'b1; high_q <= idx_q;
                eff_q <= lo_hit ? '0 : acc_q - eff_q;
              end else begin
                if (lo_hit) eff_q <= acc_q;
                acc_q <= acc_n;
                if (started_q || lo_hit) lvl_q <= lvl_q + prod;
                if (idx_q == AW'(Bins - 1)) ended_q <= 1'b1;
              end
            end else begin
              acc_q <= acc_n; eff_q <= acc_n; lvl_q <= lvl_q + prod;
              if (top_hit) begin
                ended_q <= 1'b1; started_q <= 1'b1; high_q <= bin_w;
              end else if (idx_q == AW'(Bins - 1)) ended_q <= 1'b1;
            end
          end
        end
      end
      BK_DIVA: if (div_done) avg_q <= div_quo;
      BK_DIVG: if (div_done) gain_q <= div_quo;
      BK_DONE: ;
      default: ;
    endcase
  end

  // set when the walk stopped on a threshold rather than running out of bins
  always_ff @(posedge clk_i) begin
    if (state_q == BK_RUN) hit_q <= 1'b0;
    else if (state_q == BK_WALK && !ended_q && phase_q && (mode_q ? top_hit : acc5 >= ref4))
      hit_q <= 1'b1;
  end

  always_comb begin
    low_bin_o  = mode_q ? 8'd0 : 8'(low_q);
    high_bin_o = 8'(high_q);
    avg_o      = avg_q;
    gain_o     = gain_q;
    status_o   = StatOk;
    if (!hit_q) begin
      status_o = StatNoThresh; avg_o = 16'd0; high_bin_o = 8'd0; gain_o = 16'hFFFF;
    end else if (eff_q == '0 || lvl_q == '0) begin
      status_o = StatEmpty; avg_o = 16'd0; gain_o = 16'hFFFF;
    end
  end
endmodule

// ----- sv/histogram_trimmed_mean_gain.sv -----
// Top level of the histogram trimmed mean gain block: config registers, front and back.
// Depends on htmg_pkg, htmg_front, htmg_back.
//  channel   signals                                  transfer
//  pixels    start pixel_i row_i last_i / busy        start && !busy
//  config    cfg_we_i cfg_index_i cfg_data_i          cfg_we_i
//  result    done_o gain_o .. status_o                done_o, one cycle
// Pixels transfer into a 4-entry queue; the back reads and writes back the bin of a
// counted pixel, taking no new pixel meanwhile, and just pops one outside the band.
// At frame end: a hand-over, a walk over the bins, two divisions (average, then gain),
// the result, then a pass that clears the RAM; busy is high while the queue is full.
// After reset the block first clears the RAM. Results cannot be stalled.
module histogram_trimmed_mean_gain #(
  parameter int unsigned Bins       = htmg_pkg::DefBins,
  parameter int unsigned CountWidth = htmg_pkg::DefCountWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    pixel_i,
  input  logic [htmg_pkg::RowWidth-1:0] row_i,
  input  logic                          last_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [htmg_pkg::CfgWidth-1:0] cfg_data_i,
  output logic                          done_o,
  output logic [15:0]                   gain_o,
  output logic [15:0]                   average_level_o,
  output logic [7:0]                    low_bin_o,
  output logic [7:0]                    high_bin_o,
  output logic [1:0]                    status_o
);
  import htmg_pkg::*;

  logic                mode_q;
  logic [RowWidth-1:0] first_q, lastr_q;
  logic [CfgWidth-1:0] ref_q;
  logic                full, empty, pop, idle;
  item_t               head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; first_q <= 12'd320; lastr_q <= 12'd4095; ref_q <= 20'd102400;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegMode:     mode_q  <= cfg_data_i[0];
        RegFirstRow: first_q <= cfg_data_i[RowWidth-1:0];
        RegLastRow:  lastr_q <= cfg_data_i[RowWidth-1:0];
        RegRefCount: ref_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = full;

  htmg_front #(.Bins(Bins)) u_front (
    .clk_i, .rst_ni, .take_i(start && !busy), .pixel_i, .row_i, .last_i,
    .first_row_i(first_q), .last_row_i(lastr_q), .pop_i(pop),
    .full_o(full), .empty_o(empty), .head_o(head)
  );

  htmg_back #(.Bins(Bins), .CountWidth(CountWidth)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head), .pop_o(pop), .idle_o(idle),
    .mode_i(mode_q), .ref_i(ref_q), .valid_o(done_o), .gain_o, .avg_o(average_level_o),
    .low_bin_o, .high_bin_o, .status_o
  );

  logic unused_idle;
  assign unused_idle = idle;
endmodule
